[hw/rtl/dts_pkg.sv]
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the dirty-rectangle tile splitter: payload
// structs, configuration struct, controller commands and states.
// ----------------------------------------------------------------------------
package dts_pkg;

   // coordinate and index widths
   localparam int CoordW    = 13;
   localparam int LeftW     = 12;
   localparam int TileW     = 11;
   localparam int GridW     = 7;
   localparam int OffsetW   = 10;
   localparam int IndexW    = 6;
   localparam int RowBaseW  = CoordW + GridW;
   localparam int IdxFullW  = RowBaseW + 1;
   localparam int CountW    = 7;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 11;

   // walk position can step one tile past the last 13-bit coordinate
   localparam int WalkW     = CoordW + 1;

   // most results one rectangle may produce
   localparam logic [CountW-1:0] RESULT_CAP = 7'd64;

   // largest tile edge
   localparam logic [TileW-1:0] TILE_MAX = 11'd1024;

   // result status codes
   localparam logic [1:0] STATUS_TILE    = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;

   // configuration register indexes
   localparam logic [CsrIndexW-1:0] CSR_TILE_EDGE    = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_GRID_COLUMNS = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_GRID_ROWS    = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_WHOLE_TILE   = 2'd3;

   typedef struct packed {
      logic [11:0] rect_left;
      logic [11:0] rect_top;
      logic [12:0] rect_right;
      logic [12:0] rect_bottom;
   } req_type;

   typedef struct packed {
      logic [5:0]  tile_index;
      logic [9:0]  offset_x;
      logic [9:0]  offset_y;
      logic [10:0] span_width;
      logic [10:0] span_height;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // configuration as seen by the datapath (tile size already clamped)
   typedef struct packed {
      logic [TileW-1:0] tile_edge;
      logic [GridW-1:0] grid_columns;
      logic [GridW-1:0] grid_rows;
      logic             whole_tile_mode;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_empty;
      logic div_start;
      logic setup;
      logic load_tile;
      logic load_outside;
      logic set_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rect_empty;
      logic div_done;
      logic pos_end;
      logic pos_out;
      logic cap;
   } stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FIRST,
      ST_WALK,
      ST_FINAL
   } state_type;

endpackage

[hw/rtl/dts_divider.sv]
// ----------------------------------------------------------------------------
// dts_divider
// Two restoring dividers sharing one divisor, one quotient bit per cycle.
// Gives the start tile column and row of a rectangle and the remainders.
// ----------------------------------------------------------------------------
module dts_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dts_pkg::LeftW-1:0]      dividend_a,
   input  logic [dts_pkg::LeftW-1:0]      dividend_b,
   input  logic [dts_pkg::TileW-1:0]      divisor,
   output logic [dts_pkg::LeftW-1:0]      quot_a,
   output logic [dts_pkg::LeftW-1:0]      quot_b,
   output logic [dts_pkg::LeftW-1:0]      rem_a,
   output logic [dts_pkg::LeftW-1:0]      rem_b,
   output logic                           done
);

   localparam int W    = dts_pkg::LeftW;
   localparam int CntW = $clog2(W);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]    qa_ff, qa_in, qb_ff, qb_in;
   logic [W-1:0]    ra_ff, ra_in, rb_ff, rb_in;
   logic [W-1:0]    dv_ff, dv_in;

   logic [W-1:0]    ra_shift, rb_shift;
   logic            ra_ge, rb_ge;

   // one restoring step on both dividends
   always_comb begin
      ra_shift = {ra_ff[W-2:0], qa_ff[W-1]};
      rb_shift = {rb_ff[W-2:0], qb_ff[W-1]};
      ra_ge    = ra_shift >= dv_ff;
      rb_ge    = rb_shift >= dv_ff;
   end

   // step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qa_in   = qa_ff;
      qb_in   = qb_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      dv_in   = dv_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(W - 1);
         qa_in   = dividend_a;
         qb_in   = dividend_b;
         ra_in   = '0;
         rb_in   = '0;
         dv_in   = W'(divisor);
      end else if (busy_ff) begin
         ra_in = ra_ge ? ra_shift - dv_ff : ra_shift;
         rb_in = rb_ge ? rb_shift - dv_ff : rb_shift;
         qa_in = {qa_ff[W-2:0], ra_ge};
         qb_in = {qb_ff[W-2:0], rb_ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      qa_ff <= qa_in;
      qb_ff <= qb_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      dv_ff <= dv_in;
   end

   assign quot_a = qa_ff;
   assign quot_b = qb_ff;
   assign rem_a  = ra_ff;
   assign rem_b  = rb_ff;
   assign done   = done_ff;

endmodule

[hw/rtl/dts_datapath.sv]
// ----------------------------------------------------------------------------
// dts_datapath
// Walk position, tile bounds, clipping and the result register. Driven by
// commands from the controller; reports walk status back.
// ----------------------------------------------------------------------------
module dts_datapath #(
   parameter int MAX_TILES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  dts_pkg::cfg_type    cfg,
   input  dts_pkg::req_type    req_data,
   input  dts_pkg::cmd_type    cmd,
   output dts_pkg::stat_type   stat,
   output dts_pkg::rsp_type    rsp_data
);

   localparam int CW = dts_pkg::WalkW;
   localparam int RW = dts_pkg::RowBaseW;
   localparam int IW = dts_pkg::IdxFullW;
   localparam int NW = dts_pkg::CountW;

   // rectangle registers
   logic [CW-1:0] left_ff, top_ff, right_ff, bottom_ff;
   // walk registers
   logic [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [CW-1:0] col0_ff, col0_in, tx0_ff, tx0_in;
   logic [RW-1:0] rbase_ff, rbase_in;
   logic [NW-1:0] count_ff, count_in;
   dts_pkg::rsp_type rsp_ff, rsp_in;

   // divider
   logic [dts_pkg::LeftW-1:0] quot_a, quot_b, rem_a, rem_b;
   logic                      div_done;

   dts_divider u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.div_start),
      .dividend_a (req_data.rect_left),
      .dividend_b (req_data.rect_top),
      .divisor    (cfg.tile_edge),
      .quot_a     (quot_a),
      .quot_b     (quot_b),
      .rem_a      (rem_a),
      .rem_b      (rem_b),
      .done       (div_done)
   );

   // tile geometry at the current position
   logic [CW-1:0] ts, tr, tb;
   logic [CW-1:0] ox, oy, w_rect, h_rect, w_tile, h_tile, w, h;
   logic [IW-1:0] idx_full;

   always_comb begin
      ts       = CW'(cfg.tile_edge);
      tr       = tx_ff + ts;
      tb       = ty_ff + ts;
      ox       = x_ff - tx_ff;
      oy       = y_ff - ty_ff;
      w_rect   = right_ff - x_ff;
      h_rect   = bottom_ff - y_ff;
      w_tile   = tr - x_ff;
      h_tile   = tb - y_ff;
      w        = (w_tile < w_rect) ? w_tile : w_rect;
      h        = (h_tile < h_rect) ? h_tile : h_rect;
      idx_full = IW'(rbase_ff) + IW'(col_ff);
   end

   // status to controller
   always_comb begin
      stat.rect_empty = ({1'b0, req_data.rect_left} >= req_data.rect_right) ||
                        ({1'b0, req_data.rect_top} >= req_data.rect_bottom);
      stat.div_done   = div_done;
      stat.pos_end    = y_ff >= bottom_ff;
      stat.pos_out    = (col_ff >= CW'(cfg.grid_columns)) ||
                        (row_ff >= CW'(cfg.grid_rows)) ||
                        (idx_full >= IW'(MAX_TILES));
      stat.cap        = count_ff == dts_pkg::RESULT_CAP;
   end

   // walk update
   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      col0_in  = col0_ff;
      tx0_in   = tx0_ff;
      rbase_in = rbase_ff;
      count_in = count_ff;
      if (cmd.setup) begin
         col0_in  = CW'(quot_a);
         tx0_in   = left_ff - CW'(rem_a);
         col_in   = CW'(quot_a);
         row_in   = CW'(quot_b);
         tx_in    = left_ff - CW'(rem_a);
         ty_in    = top_ff - CW'(rem_b);
         x_in     = left_ff;
         y_in     = top_ff;
         rbase_in = RW'(quot_b) * RW'(cfg.grid_columns);
         count_in = '0;
      end else if (cmd.load_tile) begin
         count_in = count_ff + 1'b1;
         if (right_ff <= tr) begin
            // next tile row, back to the left edge
            x_in     = left_ff;
            col_in   = col0_ff;
            tx_in    = tx0_ff;
            y_in     = tb;
            ty_in    = tb;
            row_in   = row_ff + 1'b1;
            rbase_in = rbase_ff + RW'(cfg.grid_columns);
         end else begin
            x_in   = tr;
            tx_in  = tr;
            col_in = col_ff + 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_empty) begin
         rsp_in        = '0;
         rsp_in.status = dts_pkg::STATUS_EMPTY;
         rsp_in.last   = 1'b1;
      end else if (cmd.load_outside) begin
         rsp_in        = '0;
         rsp_in.status = dts_pkg::STATUS_OUTSIDE;
         rsp_in.last   = 1'b1;
      end else if (cmd.load_tile) begin
         rsp_in.tile_index = idx_full[dts_pkg::IndexW-1:0];
         rsp_in.status     = dts_pkg::STATUS_TILE;
         rsp_in.last       = 1'b0;
         if (cfg.whole_tile_mode) begin
            rsp_in.offset_x    = '0;
            rsp_in.offset_y    = '0;
            rsp_in.span_width  = cfg.tile_edge;
            rsp_in.span_height = cfg.tile_edge;
         end else begin
            rsp_in.offset_x    = ox[dts_pkg::OffsetW-1:0];
            rsp_in.offset_y    = oy[dts_pkg::OffsetW-1:0];
            rsp_in.span_width  = w[dts_pkg::TileW-1:0];
            rsp_in.span_height = h[dts_pkg::TileW-1:0];
         end
      end else if (cmd.set_last) begin
         rsp_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         left_ff   <= CW'(req_data.rect_left);
         top_ff    <= CW'(req_data.rect_top);
         right_ff  <= CW'(req_data.rect_right);
         bottom_ff <= CW'(req_data.rect_bottom);
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      col0_ff  <= col0_in;
      tx0_ff   <= tx0_in;
      rbase_ff <= rbase_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[hw/rtl/dts_ctrl.sv]
// ----------------------------------------------------------------------------
// dts_ctrl
// Controller state machine: accepts a rectangle, runs the divider, steps the
// tile walk and decides which result closes the rectangle.
// ----------------------------------------------------------------------------
module dts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dts_pkg::stat_type   stat,
   output dts_pkg::cmd_type    cmd
);

   dts_pkg::state_type state_ff, state_in;
   logic               stop;

   // walk ends here: bottom reached, or result limit hit
   assign stop = stat.pos_end || stat.cap;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dts_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.rect_empty ? dts_pkg::ST_FINAL : dts_pkg::ST_DIVIDE;
            end
         end
         dts_pkg::ST_DIVIDE: begin
            if (stat.div_done) begin
               state_in = dts_pkg::ST_FIRST;
            end
         end
         dts_pkg::ST_FIRST: begin
            state_in = stat.pos_out ? dts_pkg::ST_FINAL : dts_pkg::ST_WALK;
         end
         dts_pkg::ST_WALK: begin
            if (stop) begin
               state_in = dts_pkg::ST_FINAL;
            end else if (rsp_ready && stat.pos_out) begin
               state_in = dts_pkg::ST_FINAL;
            end
         end
         dts_pkg::ST_FINAL: begin
            if (rsp_ready) begin
               state_in = dts_pkg::ST_IDLE;
            end
         end
         default: state_in = dts_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         dts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept     = 1'b1;
               cmd.load_empty = stat.rect_empty;
               cmd.div_start  = !stat.rect_empty;
            end
         end
         dts_pkg::ST_DIVIDE: begin
            cmd.setup = stat.div_done;
         end
         dts_pkg::ST_FIRST: begin
            cmd.load_outside = stat.pos_out;
            cmd.load_tile    = !stat.pos_out;
         end
         dts_pkg::ST_WALK: begin
            // pending tile goes out unless it is the closing one
            if (stop) begin
               cmd.set_last = 1'b1;
            end else begin
               rsp_valid = 1'b1;
               if (rsp_ready) begin
                  cmd.load_outside = stat.pos_out;
                  cmd.load_tile    = !stat.pos_out;
               end
            end
         end
         dts_pkg::ST_FINAL: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/dirty_rect_tile_splitter_core.sv]
// ----------------------------------------------------------------------------
// dirty_rect_tile_splitter_core
// Splits an updated rectangle into per-tile sub-updates over a grid of square tiles.
// Empty rectangle: one result, valid in the cycle after acceptance.
// Otherwise: start-tile division, a setup step and a first-tile step,
// then one result per cycle while rsp_ready is high, and a closing step.
// The next rectangle is accepted once the closing result has been taken.
// Reset (synchronous, active high): idle, registers at 128 / 1 / 1 / 0.
// ----------------------------------------------------------------------------
module dirty_rect_tile_splitter_core #(
   parameter int MAX_TILES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dts_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dts_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [dts_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [dts_pkg::CsrDataW-1:0]        csr_wdata
);

   // configuration registers
   logic [dts_pkg::TileW-1:0] tile_edge_ff;
   logic [dts_pkg::GridW-1:0] grid_columns_ff;
   logic [dts_pkg::GridW-1:0] grid_rows_ff;
   logic                      whole_tile_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_edge_ff    <= 11'd128;
         grid_columns_ff <= 7'd1;
         grid_rows_ff    <= 7'd1;
         whole_tile_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            dts_pkg::CSR_TILE_EDGE:    tile_edge_ff    <= csr_wdata;
            dts_pkg::CSR_GRID_COLUMNS: grid_columns_ff <= csr_wdata[dts_pkg::GridW-1:0];
            dts_pkg::CSR_GRID_ROWS:    grid_rows_ff    <= csr_wdata[dts_pkg::GridW-1:0];
            dts_pkg::CSR_WHOLE_TILE:   whole_tile_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamp tile size to 1..1024
   dts_pkg::cfg_type cfg;

   always_comb begin
      if (tile_edge_ff == '0) begin
         cfg.tile_edge = dts_pkg::TileW'(1);
      end else if (tile_edge_ff > dts_pkg::TILE_MAX) begin
         cfg.tile_edge = dts_pkg::TILE_MAX;
      end else begin
         cfg.tile_edge = tile_edge_ff;
      end
      cfg.grid_columns    = grid_columns_ff;
      cfg.grid_rows       = grid_rows_ff;
      cfg.whole_tile_mode = whole_tile_ff;
   end

   dts_pkg::cmd_type  cmd;
   dts_pkg::stat_type stat;

   dts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dts_datapath #(
      .MAX_TILES (MAX_TILES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
